@@ hdl/gzhp_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the gzip header parser.
// No dependencies.
package gzhp_pkg;

	localparam int unsigned MAX_HEADER_BYTES = 8192;
	// Byte counter holds values up to and including the header limit
	localparam int unsigned CNT_W = $clog2(MAX_HEADER_BYTES + 1);
	localparam int unsigned LEN_W = 14;
	localparam int unsigned FIXED_BYTES = 10;
	localparam int unsigned FLAG_BYTE_POS = 4;

	localparam logic [7:0] MAGIC1 = 8'h1F;
	localparam logic [7:0] MAGIC2 = 8'h8B;
	localparam logic [7:0] FLAG_MASK = 8'h1F;

	localparam logic [4:0] FL_HCRC    = 5'h02;
	localparam logic [4:0] FL_EXTRA   = 5'h04;
	localparam logic [4:0] FL_NAME    = 5'h08;
	localparam logic [4:0] FL_COMMENT = 5'h10;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOT_GZIP = 3'd1,
		ST_FLAGS    = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_CRC      = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] header_length;
	} verdict_t;

	// Reflected CRC-32, one byte, bitwise
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/gzip_header_parser.sv @@
// Gzip member header parser: per-byte state update, one-byte CRC-32 and a
// two-entry verdict register. Depends on gzhp_pkg.
//
// Takes one header byte per cycle, no gaps required, while byte_stall is low;
// gives one registered verdict (status and header length) per header for the
// byte that decides it. Throughput is one byte per clock while not stalled, set
// by the per-byte phase update and the single CRC-32 byte step. Verdicts sit in
// an output register backed by a skid register, so byte_stall only rises once
// two verdicts are waiting. Bytes after a verdict up to last_byte are swallowed.
module gzip_header_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  gzhp_pkg::byte_req_t byte_req,
	output logic                verdict_valid,
	input  logic                verdict_stall,
	output gzhp_pkg::verdict_t  verdict
);

	typedef enum logic [3:0] {
		PH_WAIT, PH_MAGIC2, PH_FIXED, PH_FIXED_BAD, PH_XLEN_LO, PH_XLEN_HI,
		PH_EXTRA, PH_NAME, PH_COMMENT, PH_HCRC_LO, PH_HCRC_HI, PH_DRAIN, PH_COMPLETE
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [gzhp_pkg::CNT_W-1:0]   count_q, count_d, count_base;
	logic [4:0]                   flags_q, flags_d, flags_base;
	logic [15:0]                  extra_q, extra_d, extra_base;
	logic [7:0]                   xlen_lo_q, xlen_lo_d;
	logic [31:0]                  crc_q, crc_d, crc_base;
	logic [7:0]                   crc_lo_q, crc_lo_d;

	logic                         accept, push, hit;
	gzhp_pkg::status_t            st;
	logic [gzhp_pkg::LEN_W-1:0]   len;
	gzhp_pkg::verdict_t           push_data;

	logic                         out_valid_q, skid_valid_q;
	gzhp_pkg::verdict_t           out_q, skid_q;
	logic                         out_take;

	logic [7:0] b;
	logic       last;

	function automatic phase_t section_from(input phase_t ph, input logic [4:0] fl);
		phase_t r;
		if (ph <= PH_XLEN_LO && (fl & gzhp_pkg::FL_EXTRA) != 5'd0)
			r = PH_XLEN_LO;
		else if (ph <= PH_NAME && (fl & gzhp_pkg::FL_NAME) != 5'd0)
			r = PH_NAME;
		else if (ph <= PH_COMMENT && (fl & gzhp_pkg::FL_COMMENT) != 5'd0)
			r = PH_COMMENT;
		else if (ph <= PH_HCRC_LO && (fl & gzhp_pkg::FL_HCRC) != 5'd0)
			r = PH_HCRC_LO;
		else
			r = PH_COMPLETE;
		return r;
	endfunction

	assign b = byte_req.data_byte;
	assign last = byte_req.last_byte;
	assign byte_stall = skid_valid_q;
	assign accept = byte_valid && !byte_stall;

	always_comb begin
		// A new header starts from cleared fields
		count_base = (phase_q == PH_WAIT) ? '0 : count_q;
		flags_base = (phase_q == PH_WAIT) ? '0 : flags_q;
		extra_base = (phase_q == PH_WAIT) ? '0 : extra_q;
		crc_base   = (phase_q == PH_WAIT) ? gzhp_pkg::CRC_INIT : crc_q;

		phase_d   = phase_q;
		flags_d   = flags_base;
		extra_d   = extra_base;
		xlen_lo_d = (phase_q == PH_WAIT) ? 8'd0 : xlen_lo_q;
		crc_lo_d  = (phase_q == PH_WAIT) ? 8'd0 : crc_lo_q;
		count_d   = count_base + 1'b1;
		crc_d     = (phase_q == PH_HCRC_LO || phase_q == PH_HCRC_HI) ? crc_base :
			gzhp_pkg::crc_byte(crc_base, b);
		hit = 1'b0;
		st  = gzhp_pkg::ST_OK;
		len = '0;

		case (phase_q)
			PH_WAIT: begin
				if (b == gzhp_pkg::MAGIC1) phase_d = PH_MAGIC2;
				else begin
					hit = 1'b1;
					st  = gzhp_pkg::ST_NOT_GZIP;
				end
			end
			PH_MAGIC2: begin
				if (b == gzhp_pkg::MAGIC2) phase_d = PH_FIXED;
				else begin
					hit = 1'b1;
					st  = gzhp_pkg::ST_NOT_GZIP;
				end
			end
			PH_FIXED, PH_FIXED_BAD: begin
				if (count_d == gzhp_pkg::CNT_W'(gzhp_pkg::FLAG_BYTE_POS)) begin
					flags_d = b[4:0];
					if ((b & ~gzhp_pkg::FLAG_MASK) != 8'd0) phase_d = PH_FIXED_BAD;
				end
				if (count_d >= gzhp_pkg::CNT_W'(gzhp_pkg::FIXED_BYTES)) begin
					if (phase_q == PH_FIXED_BAD) begin
						hit = 1'b1;
						st  = gzhp_pkg::ST_FLAGS;
					end else begin
						phase_d = section_from(PH_XLEN_LO, flags_d);
					end
				end
			end
			PH_XLEN_LO: begin
				xlen_lo_d = b;
				phase_d   = PH_XLEN_HI;
			end
			PH_XLEN_HI: begin
				extra_d = {b, xlen_lo_q};
				phase_d = ({b, xlen_lo_q} != 16'd0) ? PH_EXTRA : section_from(PH_NAME, flags_q);
			end
			PH_EXTRA: begin
				extra_d = extra_q - 1'b1;
				if (extra_q == 16'd1) phase_d = section_from(PH_NAME, flags_q);
			end
			PH_NAME: begin
				if (b == 8'd0) phase_d = section_from(PH_COMMENT, flags_q);
			end
			PH_COMMENT: begin
				if (b == 8'd0) phase_d = section_from(PH_HCRC_LO, flags_q);
			end
			PH_HCRC_LO: begin
				crc_lo_d = b;
				phase_d  = PH_HCRC_HI;
			end
			PH_HCRC_HI: begin
				hit = 1'b1;
				if (~crc_q[15:0] == {b, crc_lo_q}) phase_d = PH_COMPLETE;
				else st = gzhp_pkg::ST_CRC;
			end
			default: begin
				hit = 1'b1;
				st  = gzhp_pkg::ST_TRUNC;
			end
		endcase

		if (phase_d == PH_COMPLETE) begin
			hit = 1'b1;
			st  = gzhp_pkg::ST_OK;
			len = count_d[gzhp_pkg::LEN_W-1:0];
		end else if (!hit) begin
			if (count_d >= gzhp_pkg::CNT_W'(gzhp_pkg::MAX_HEADER_BYTES)) begin
				hit = 1'b1;
				st  = gzhp_pkg::ST_TRUNC;
			end else if (last) begin
				hit = 1'b1;
				st  = (count_d < gzhp_pkg::CNT_W'(gzhp_pkg::FIXED_BYTES)) ?
					gzhp_pkg::ST_NOT_GZIP : gzhp_pkg::ST_TRUNC;
			end
		end

		// Drain swallows bytes; a marked last byte always restarts the search
		if (phase_q == PH_DRAIN) begin
			hit = 1'b0;
			phase_d = last ? PH_WAIT : PH_DRAIN;
		end else if (last) begin
			phase_d = PH_WAIT;
		end else if (hit) begin
			phase_d = PH_DRAIN;
		end
	end

	assign push = accept && hit;
	assign push_data = '{status: st, header_length: len};
	assign out_take = out_valid_q && !verdict_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			count_q      <= '0;
			flags_q      <= '0;
			extra_q      <= '0;
			xlen_lo_q    <= '0;
			crc_q        <= gzhp_pkg::CRC_INIT;
			crc_lo_q     <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				count_q   <= count_d;
				flags_q   <= flags_d;
				extra_q   <= extra_d;
				xlen_lo_q <= xlen_lo_d;
				crc_q     <= crc_d;
				crc_lo_q  <= crc_lo_d;
			end
			if (!out_valid_q || out_take) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= push;
					out_q        <= skid_q;
					if (push) skid_q <= push_data;
				end else begin
					out_valid_q  <= push;
					if (push) out_q <= push_data;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
				skid_q       <= push_data;
			end
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict = out_q;

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a verdict while output register is empty");

	a_no_verdict_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_DRAIN) |-> !push)
		else $error("verdict raised while draining the stream");

	a_ok_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		(push && st == gzhp_pkg::ST_OK) |-> (len >= gzhp_pkg::LEN_W'(gzhp_pkg::FIXED_BYTES)))
		else $error("ok verdict with a header shorter than the fixed part");

	a_fail_zero_length: assert property (@(posedge clk) disable iff (!arst_n)
		(push && st != gzhp_pkg::ST_OK) |-> (len == '0))
		else $error("failed verdict carries a header length");

	a_verdict_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !last) |=> (phase_q == PH_DRAIN))
		else $error("no drain after a verdict on a non-final byte");

endmodule
